// ----- sv/weo_pkg.sv -----
// Shared types, codes and constants for the wheel encoder odometry block.
`timescale 1ns / 1ps

package weo_pkg;

    // Mode codes of an input word
    localparam logic [1:0] MODE_POLL         = 2'd0;
    localparam logic [1:0] MODE_FULL_RESET   = 2'd1;
    localparam logic [1:0] MODE_TRAVEL_RESET = 2'd2;

    // Configuration register indexes
    localparam logic CFG_IDX_SIGN  = 1'b0;
    localparam logic CFG_IDX_CLAMP = 1'b1;

    localparam int CFG_DATA_W = 31;

    localparam logic [30:0] CLAMP_RESET  = 31'h7FFF_FFFF;
    localparam logic [30:0] TRAVEL_MAX   = 31'h7FFF_FFFF;
    localparam logic [16:0] SPEED_SAT    = 17'h0_FFFF;

    typedef struct packed {
        logic        sign_negative;
        logic [30:0] dist_clamp;
    } weo_cfg_t;

    typedef struct packed {
        logic [15:0]        last_left;
        logic [15:0]        last_right;
        logic signed [17:0] speed;
        logic signed [31:0] dist_left;
        logic signed [31:0] dist_right;
        logic [31:0]        diff_accum;
        logic [30:0]        travel_accum;
    } weo_state_t;

    typedef struct packed {
        logic signed [16:0] wheel_speed;
        logic signed [31:0] distance_left;
        logic signed [31:0] distance_right;
        logic signed [31:0] straight_diff;
        logic [30:0]        travel_total;
    } weo_result_t;

endpackage

// ----- sv/weo_if.sv -----
// Valid/ready channel interfaces for input words and result words.
`timescale 1ns / 1ps

interface weo_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [15:0] count_left;
    logic [15:0] count_right;

    modport source (output valid, output mode, output count_left, output count_right,
                    input ready);
    modport sink   (input valid, input mode, input count_left, input count_right,
                    output ready);
endinterface

interface weo_out_if;
    logic               valid;
    logic               ready;
    logic signed [16:0] wheel_speed;
    logic signed [31:0] distance_left;
    logic signed [31:0] distance_right;
    logic signed [31:0] straight_diff;
    logic [30:0]        travel_total;

    modport source (output valid, output wheel_speed, output distance_left,
                    output distance_right, output straight_diff, output travel_total,
                    input ready);
    modport sink   (input valid, input wheel_speed, input distance_left,
                    input distance_right, input straight_diff, input travel_total,
                    output ready);
endinterface

// ----- sv/wheel_encoder_odometry.sv -----
// Top level: input register, odometry update and result register.
`timescale 1ns / 1ps

// An accepted input word is held in the input register; its result word then passes
// through the result register, where it stays while the sink holds ready low.
// Throughput: one word per cycle unless the result register stalls; the adders and
// clamps update the state combinationally between the input and result registers.
// Reset: rst_n clears all state, baseline counts and accumulators to zero,
// sets sign to keep and distance clamp to 2^31-1; both stages come up empty.
module wheel_encoder_odometry (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic                                cfg_index,
    input  logic [weo_pkg::CFG_DATA_W-1:0]      cfg_data,
    weo_in_if.sink                              odo_in,
    weo_out_if.source                           odo_out
);
    import weo_pkg::*;

    weo_cfg_t    cfg_reg;
    weo_state_t  state_reg;
    weo_state_t  state_next;
    weo_result_t result_next;
    weo_result_t result_reg;

    logic        s1_valid_reg;
    logic [1:0]  s1_mode_reg;
    logic [15:0] s1_left_reg;
    logic [15:0] s1_right_reg;
    logic        out_valid_reg;

    logic        out_free;
    logic        s1_fire;
    logic        in_fire;

    // Handshake: input stage moves on whenever the result register can take a word
    assign out_free     = !out_valid_reg || odo_out.ready;
    assign s1_fire      = s1_valid_reg && out_free;
    assign odo_in.ready = !s1_valid_reg || out_free;
    assign in_fire      = odo_in.valid && odo_in.ready;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sign_negative <= 1'b0;
            cfg_reg.dist_clamp    <= CLAMP_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_IDX_SIGN:  cfg_reg.sign_negative <= cfg_data[0];
                CFG_IDX_CLAMP: cfg_reg.dist_clamp    <= cfg_data[30:0];
                default:       cfg_reg               <= cfg_reg;
            endcase
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (odo_in.ready)
        begin
            s1_valid_reg <= odo_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_mode_reg  <= odo_in.mode;
            s1_left_reg  <= odo_in.count_left;
            s1_right_reg <= odo_in.count_right;
        end
    end

    // Odometry update
    weo_update u_update (
        .mode        (s1_mode_reg),
        .count_left  (s1_left_reg),
        .count_right (s1_right_reg),
        .cfg         (cfg_reg),
        .state_cur   (state_reg),
        .state_next  (state_next),
        .result      (result_next)
    );

    // Odometry state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (s1_fire)
        begin
            state_reg <= state_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            result_reg <= result_next;
        end
    end

    assign odo_out.valid          = out_valid_reg;
    assign odo_out.wheel_speed    = result_reg.wheel_speed;
    assign odo_out.distance_left  = result_reg.distance_left;
    assign odo_out.distance_right = result_reg.distance_right;
    assign odo_out.straight_diff  = result_reg.straight_diff;
    assign odo_out.travel_total   = result_reg.travel_total;

endmodule

// ----- sv/weo_update.sv -----
// Odometry update logic: wheel deltas, clamped distances, difference and travel.
`timescale 1ns / 1ps

module weo_update (
    input  logic [1:0]           mode,
    input  logic [15:0]          count_left,
    input  logic [15:0]          count_right,
    input  weo_pkg::weo_cfg_t    cfg,
    input  weo_pkg::weo_state_t  state_cur,
    output weo_pkg::weo_state_t  state_next,
    output weo_pkg::weo_result_t result
);
    import weo_pkg::*;

    logic [15:0]        raw_l;
    logic [15:0]        raw_r;
    logic signed [16:0] ext_l;
    logic signed [16:0] ext_r;
    logic signed [16:0] dl;
    logic signed [16:0] dr;
    logic [16:0]        abs_l;
    logic [16:0]        abs_r;
    logic signed [17:0] speed_sum;
    logic signed [17:0] diff_step;
    logic [31:0]        travel_sum;
    logic signed [31:0] dist_l_new;
    logic signed [31:0] dist_r_new;

    // Add a delta to a distance at full width, then clamp to +-limit
    function automatic logic signed [31:0] clamp_add(
        input logic signed [31:0] acc,
        input logic signed [16:0] delta,
        input logic [30:0]        lim
    );
        logic signed [33:0] sum;
        logic signed [33:0] lim_pos;
        logic signed [33:0] lim_neg;
        logic signed [33:0] res;
        sum     = $signed({{2{acc[31]}}, acc}) + $signed({{17{delta[16]}}, delta});
        lim_pos = $signed({3'b000, lim});
        lim_neg = -lim_pos;
        if (sum > lim_pos)
            res = lim_pos;
        else if (sum < lim_neg)
            res = lim_neg;
        else
            res = sum;
        return res[31:0];
    endfunction

    // Wrapped 16-bit deltas, sign extended, optionally negated
    always_comb
    begin
        raw_l = count_left - state_cur.last_left;
        raw_r = count_right - state_cur.last_right;
        ext_l = $signed({raw_l[15], raw_l});
        ext_r = $signed({raw_r[15], raw_r});
        dl    = cfg.sign_negative ? -ext_l : ext_l;
        dr    = cfg.sign_negative ? -ext_r : ext_r;
        abs_l = dl[16] ? 17'(-dl) : 17'(dl);
        abs_r = dr[16] ? 17'(-dr) : 17'(dr);
        speed_sum = $signed({dl[16], dl}) + $signed({dr[16], dr});
        diff_step = $signed({dl[16], dl}) - $signed({dr[16], dr});
        travel_sum = {1'b0, state_cur.travel_accum} + {15'd0, abs_l} + {15'd0, abs_r};
        dist_l_new = clamp_add(state_cur.dist_left, dl, cfg.dist_clamp);
        dist_r_new = clamp_add(state_cur.dist_right, dr, cfg.dist_clamp);
    end

    // Next state by mode
    always_comb
    begin
        state_next = state_cur;
        unique case (mode)
            MODE_POLL:
            begin
                state_next.last_left    = count_left;
                state_next.last_right   = count_right;
                state_next.speed        = speed_sum;
                state_next.dist_left    = dist_l_new;
                state_next.dist_right   = dist_r_new;
                state_next.diff_accum   = state_cur.diff_accum
                                          + {{14{diff_step[17]}}, diff_step};
                state_next.travel_accum = travel_sum[31] ? TRAVEL_MAX : travel_sum[30:0];
            end
            MODE_FULL_RESET:
            begin
                state_next.last_left    = count_left;
                state_next.last_right   = count_right;
                state_next.speed        = '0;
                state_next.dist_left    = '0;
                state_next.dist_right   = '0;
                state_next.diff_accum   = '0;
                state_next.travel_accum = '0;
            end
            MODE_TRAVEL_RESET:
            begin
                state_next.last_left    = count_left;
                state_next.last_right   = count_right;
                state_next.diff_accum   = '0;
                state_next.travel_accum = '0;
            end
            default:
            begin
                state_next = state_cur;
            end
        endcase
    end

    // Result word shows the updated state; speed field saturates at the top
    always_comb
    begin
        result.wheel_speed    = (state_next.speed > 18'sd65535) ? $signed(SPEED_SAT)
                                                                 : state_next.speed[16:0];
        result.distance_left  = state_next.dist_left;
        result.distance_right = state_next.dist_right;
        result.straight_diff  = state_next.diff_accum;
        result.travel_total   = state_next.travel_accum;
    end

endmodule

// ----- tb/wheel_encoder_odometry_checker.sv -----
// Checker that predicts the odometry result words and compares them with the block's output.
`timescale 1ns / 1ps

module wheel_encoder_odometry_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic                         cfg_index,
    input  logic [weo_pkg::CFG_DATA_W-1:0] cfg_data,
    weo_in_if                            odo_in,
    weo_out_if                           odo_out,
    output int                           errors,
    output int                           pending
);
    import weo_pkg::*;

    weo_cfg_t    cfg;
    weo_state_t  odo;
    weo_result_t expected_odometry[$];

    // Signed wheel delta from the 16-bit wrapped count difference
    function automatic int wheel_delta(logic [15:0] now_count, logic [15:0] base);
        logic [15:0] raw;
        int          d;
        raw = now_count - base;
        d = int'($signed(raw));
        return cfg.sign_negative ? -d : d;
    endfunction

    // Symmetric distance saturation at the configured limit
    function automatic logic signed [31:0] clamp_distance(longint sum);
        longint lim;
        lim = longint'(cfg.dist_clamp);
        if (sum > lim)
            sum = lim;
        if (sum < -lim)
            sum = -lim;
        return 32'(sum);
    endfunction

    // Apply one input word to the predicted state and return the result word
    function automatic weo_result_t odometry_update(logic [1:0] mode, logic [15:0] cl,
                                                    logic [15:0] cr);
        int          dl;
        int          dr;
        longint      trav;
        weo_result_t res;
        case (mode)
            MODE_POLL:
            begin
                dl = wheel_delta(cl, odo.last_left);
                dr = wheel_delta(cr, odo.last_right);
                odo.last_left  = cl;
                odo.last_right = cr;
                odo.speed      = 18'(dl + dr);
                odo.dist_left  = clamp_distance(longint'(odo.dist_left) + dl);
                odo.dist_right = clamp_distance(longint'(odo.dist_right) + dr);
                odo.diff_accum = odo.diff_accum + 32'(dl - dr);
                trav = longint'(odo.travel_accum) + (dl < 0 ? -dl : dl) + (dr < 0 ? -dr : dr);
                odo.travel_accum = (trav > longint'(TRAVEL_MAX)) ? TRAVEL_MAX : 31'(trav);
            end
            MODE_FULL_RESET:
            begin
                odo.last_left    = cl;
                odo.last_right   = cr;
                odo.speed        = '0;
                odo.dist_left    = '0;
                odo.dist_right   = '0;
                odo.diff_accum   = '0;
                odo.travel_accum = '0;
            end
            MODE_TRAVEL_RESET:
            begin
                odo.last_left    = cl;
                odo.last_right   = cr;
                odo.diff_accum   = '0;
                odo.travel_accum = '0;
            end
            default:
            begin
                // unused mode leaves everything alone
            end
        endcase
        // the speed state can reach +65536, which the 17-bit field cannot hold
        res.wheel_speed    = (odo.speed > 18'sd65535) ? SPEED_SAT : odo.speed[16:0];
        res.distance_left  = odo.dist_left;
        res.distance_right = odo.dist_right;
        res.straight_diff  = odo.diff_accum;
        res.travel_total   = odo.travel_accum;
        return res;
    endfunction

    task automatic check_field(string field, logic signed [32:0] want, logic signed [32:0] got);
        if (got !== want)
        begin
            errors++;
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
        end
    endtask

    // Output word is checked before the input word of the same edge is predicted
    always @(posedge clk or negedge rst_n)
    begin : monitor
        weo_result_t want;
        if (!rst_n)
        begin
            cfg.sign_negative = 1'b0;
            cfg.dist_clamp    = CLAMP_RESET;
            odo               = '0;
            expected_odometry.delete();
            errors            = 0;
            pending           = 0;
        end
        else
        begin
            if (odo_out.valid && odo_out.ready)
            begin
                if (expected_odometry.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result word: speed %0d, left %0d, right %0d",
                             $time, odo_out.wheel_speed, odo_out.distance_left,
                             odo_out.distance_right);
                end
                else
                begin
                    want = expected_odometry.pop_front();
                    check_field("wheel_speed", want.wheel_speed, odo_out.wheel_speed);
                    check_field("distance_left", want.distance_left, odo_out.distance_left);
                    check_field("distance_right", want.distance_right,
                                odo_out.distance_right);
                    check_field("straight_diff", want.straight_diff, odo_out.straight_diff);
                    check_field("travel_total", want.travel_total, odo_out.travel_total);
                end
            end
            if (odo_in.valid && odo_in.ready)
                expected_odometry.push_back(odometry_update(odo_in.mode, odo_in.count_left,
                                                            odo_in.count_right));
            // register writes only happen while idle
            if (cfg_we)
            begin
                if (cfg_index == CFG_IDX_SIGN)
                    cfg.sign_negative = cfg_data[0];
                else
                    cfg.dist_clamp = cfg_data;
            end
            pending = expected_odometry.size();
        end
    end

endmodule

// ----- tb/wheel_encoder_odometry_test.sv -----
// Testbench top: clock, reset, stimulus words, result sink and the final verdict.
`timescale 1ns / 1ps

module wheel_encoder_odometry_test;
    import weo_pkg::*;

    localparam logic [1:0] MODE_UNUSED  = 2'd3;
    localparam int CYCLE_LIMIT          = 1_000_000;
    localparam int LONG_HOLD            = 150;
    localparam int RANDOM_PHASES        = 6;
    localparam int WORDS_PER_PHASE      = 170;
    localparam int SATURATION_POLLS     = 64;
    localparam int SETTLE_CYCLES        = 4;

    bit                    clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic                  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    errors;
    int                    pending;
    int                    cycles;
    bit                    quiet;
    bit                    long_hold_req;
    logic [15:0]           base_left;
    logic [15:0]           base_right;

    weo_in_if  odo_in();
    weo_out_if odo_out();

    wheel_encoder_odometry i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .odo_in    (odo_in),
        .odo_out   (odo_out)
    );

    wheel_encoder_odometry_checker i_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .odo_in    (odo_in),
        .odo_out   (odo_out),
        .errors    (errors),
        .pending   (pending)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // Timeout guard
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Idle length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        return $urandom_range(4, 25);
    endfunction

    // Wheel delta: small, medium, any, or one of the edge values
    function automatic logic [15:0] pick_delta();
        case ($urandom_range(0, 3))
            0: return 16'($urandom_range(0, 128)) - 16'd64;
            1: return 16'($urandom_range(0, 4096)) - 16'd2048;
            2: return 16'($urandom);
            default:
            begin
                case ($urandom_range(0, 4))
                    0: return 16'h7FFF;
                    1: return 16'h8000;
                    2: return 16'h0001;
                    3: return 16'hFFFF;
                    default: return 16'h0000;
                endcase
            end
        endcase
    endfunction

    // Result sink with random stalls and one long hold-off on request
    initial
    begin : result_sink
        int stall;
        stall = 0;
        odo_out.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (long_hold_req)
            begin
                odo_out.ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
                long_hold_req = 1'b0;
            end
            else if (stall > 0)
            begin
                odo_out.ready <= 1'b0;
                stall--;
            end
            else
            begin
                odo_out.ready <= 1'b1;
                stall = quiet ? 0 : pick_gap();
            end
        end
    end

    // Offer one input word; valid stays high on return
    task automatic send_word(input logic [1:0] m, input logic [15:0] cl, input logic [15:0] cr);
        int gap;
        gap = quiet ? 0 : pick_gap();
        if (gap > 0)
        begin
            odo_in.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        odo_in.valid       <= 1'b1;
        odo_in.mode        <= m;
        odo_in.count_left  <= cl;
        odo_in.count_right <= cr;
        do
            @(posedge clk);
        while (!odo_in.ready);
        @(negedge clk);
        if (m != MODE_UNUSED)
        begin
            base_left  = cl;
            base_right = cr;
        end
    endtask

    task automatic poll_by(input logic [15:0] dl, input logic [15:0] dr);
        send_word(MODE_POLL, base_left + dl, base_right + dr);
    endtask

    // Stop offering and wait for every outstanding result word
    task automatic drain();
        odo_in.valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic set_config(input logic sign, input logic [30:0] clamp);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_IDX_SIGN;
        cfg_data  <= {30'b0, sign};
        @(negedge clk);
        cfg_index <= CFG_IDX_CLAMP;
        cfg_data  <= clamp;
        @(negedge clk);
        cfg_we    <= 1'b0;
        @(negedge clk);
    endtask

    task automatic random_word();
        int r;
        r = $urandom_range(0, 99);
        if (r < 84)
            poll_by(pick_delta(), pick_delta());
        else if (r < 90)
            send_word(MODE_TRAVEL_RESET, 16'($urandom), 16'($urandom));
        else if (r < 95)
            send_word(MODE_FULL_RESET, 16'($urandom), 16'($urandom));
        else
            send_word(MODE_UNUSED, 16'($urandom), 16'($urandom));
    endtask

    initial
    begin : stimulus
        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_index          = CFG_IDX_SIGN;
        cfg_data           = '0;
        odo_in.valid       = 1'b0;
        odo_in.mode        = MODE_POLL;
        odo_in.count_left  = '0;
        odo_in.count_right = '0;
        base_left          = '0;
        base_right         = '0;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: delta extremes, every mode, unused mode
        poll_by(16'h0000, 16'h0000);
        poll_by(16'h7FFF, 16'h8000);
        poll_by(16'h8000, 16'h8000);
        send_word(MODE_UNUSED, 16'h1234, 16'h5678);
        send_word(MODE_TRAVEL_RESET, 16'hAAAA, 16'h5555);
        poll_by(16'h0001, 16'hFFFF);
        send_word(MODE_FULL_RESET, 16'hFFFF, 16'hFFFF);
        poll_by(16'h0001, 16'h0001);

        // Negated deltas: speed overflow saturates the field, travel reset keeps speed
        drain();
        set_config(1'b1, CLAMP_RESET);
        poll_by(16'h8000, 16'h8000);
        send_word(MODE_UNUSED, 16'h0000, 16'h0000);
        send_word(MODE_TRAVEL_RESET, 16'h0F0F, 16'hF0F0);
        poll_by(16'h7FFF, 16'h0000);

        // Zero clamp pins both distances
        drain();
        set_config(1'b0, 31'd0);
        poll_by(16'd1000, -16'd1000);

        // Small clamp, then a tighter one applied only from the next poll
        drain();
        set_config(1'b0, 31'd5);
        poll_by(16'd3, 16'd3);
        poll_by(16'd3, 16'd3);
        poll_by(-16'd20, 16'd0);
        drain();
        set_config(1'b0, 31'd2);
        send_word(MODE_UNUSED, 16'h0000, 16'h0000);
        poll_by(16'h0000, 16'h0000);

        // Back-to-back extreme polls at full rate with the sink always ready
        drain();
        set_config(1'b0, CLAMP_RESET);
        quiet = 1'b1;
        send_word(MODE_FULL_RESET, 16'($urandom), 16'($urandom));
        for (int k = 0; k < SATURATION_POLLS; k++)
            poll_by(16'h7FFF, 16'h8000);
        quiet = 1'b0;
        poll_by(16'h8001, 16'h7FFF);

        // Random phases, each under its own register setting
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            drain();
            case (p)
                0: set_config(1'b0, CLAMP_RESET);
                1: set_config(1'b1, 31'd1000);
                2: set_config(1'b0, 31'd0);
                3: set_config(1'b1, CLAMP_RESET);
                4: set_config(1'($urandom), 31'($urandom_range(1, 100000)));
                default: set_config(1'($urandom), 31'($urandom));
            endcase
            for (int k = 0; k < WORDS_PER_PHASE; k++)
            begin
                quiet = (k >= 60 && k < 100);
                if (p == 1 && k == 20)
                    long_hold_req = 1'b1;
                random_word();
            end
        end

        drain();
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
